### rtl/wfp_pkg.sv
// ----------------------------------------------------------------------------
// wfp_pkg - shared types and constants of the websocket frame parser
// Holds the queue entry format, the parse phases and the message type codes.
// ----------------------------------------------------------------------------
package wfp_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [2:0] TYPE_TEXT    = 3'd0;
	localparam logic [2:0] TYPE_BINARY  = 3'd1;
	localparam logic [2:0] TYPE_CLOSE   = 3'd2;
	localparam logic [2:0] TYPE_PING    = 3'd3;
	localparam logic [2:0] TYPE_PONG    = 3'd4;
	localparam logic [2:0] TYPE_UNKNOWN = 3'd5;
	localparam logic [2:0] TYPE_LARGE   = 3'd6;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic REG_MAX_SIZE   = 1'b0;
	localparam logic REG_DELIVER    = 1'b1;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// results caused by one accepted byte
	typedef struct packed {
		logic       has_pay;
		logic [7:0] pay_byte;
		logic       has_end;
		logic [2:0] end_type;
		logic       end_fin;
	} entry_t;

	function automatic logic [2:0] map_opcode(input logic [3:0] op);
		logic [2:0] t;
		unique case (op)
			OP_TEXT:   t = TYPE_TEXT;
			OP_BINARY: t = TYPE_BINARY;
			OP_CLOSE:  t = TYPE_CLOSE;
			OP_PING:   t = TYPE_PING;
			OP_PONG:   t = TYPE_PONG;
			default:   t = TYPE_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

### rtl/websocket_frame_parser_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_top - WebSocket receive frame parser
// Takes one stream byte per request and returns unmasked payload bytes and
// message end records.
// ----------------------------------------------------------------------------
// One input byte is taken per clock while the output keeps up. The parser
// front classifies each byte in the cycle it is accepted and pushes its
// results (a payload byte, an end record, or both) into a four-entry queue;
// the output stage sends one result per cycle while out_stall is low, so a
// byte that causes two results sends its payload byte and then its end
// record; rx_stall rises only when the queue is full. Bytes that cause no
// result (headers, length, mask key, dropped payload) never reach the queue.
// Registers: 0x0 message size limit (25 bits, reset 65536), 0x4
// deliver_fragments (1 bit, reset 0); write them only while the block is idle.
module websocket_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  msg_type,
	output logic        fin_flag,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [24:0]     max_size_q;
	logic            deliver_q;
	logic            full;
	logic            acc;
	logic            push;
	logic            pop;
	logic            nonempty;
	wfp_pkg::entry_t push_entry;
	wfp_pkg::entry_t head;

	assign pready = 1'b1;

	// hold configuration; write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= 25'd65536;
			deliver_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				wfp_pkg::REG_MAX_SIZE: max_size_q <= pwdata[24:0];
				wfp_pkg::REG_DELIVER:  deliver_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			wfp_pkg::REG_MAX_SIZE: prdata = {7'd0, max_size_q};
			wfp_pkg::REG_DELIVER:  prdata = {31'd0, deliver_q};
			default:               prdata = 32'd0;
		endcase
	end

	// stall input only when the queue has no room
	assign rx_stall = full;
	assign acc      = rx_valid && !full;

	wfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.rx_byte    (rx_byte),
		.max_size   (max_size_q),
		.deliver    (deliver_q),
		.push       (push),
		.push_entry (push_entry)
	);

	wfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty),
		.full       (full)
	);

	wfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.nonempty     (nonempty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.msg_type     (msg_type),
		.fin_flag     (fin_flag),
		.last         (last)
	);

endmodule

### rtl/wfp_front.sv
// ----------------------------------------------------------------------------
// wfp_front - header parser and payload unmasking
// Tracks the frame phase, builds the length and mask key, and pushes the
// results of each byte as one queue entry.
// ----------------------------------------------------------------------------
module wfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          rx_byte,
	input  logic [24:0]         max_size,
	input  logic                deliver,
	output logic                push,
	output wfp_pkg::entry_t     push_entry
);

	wfp_pkg::phase_t phase_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        mask_q;
	logic [3:0]  left_q;
	logic [63:0] plen_q;
	logic [31:0] key_q;
	logic [63:0] br_q;
	logic [24:0] kept_q;
	logic [2:0]  mtype_q;
	logic        ovf_q;

	logic [6:0]  len7;
	logic [63:0] ext_len;
	logic [63:0] br_inc;
	logic        in_pay;
	logic        keep;
	logic        ovf_nxt;
	logic        end_now;
	logic        emit_end;
	logic [2:0]  type_end;
	logic [1:0]  key_idx;

	assign len7    = rx_byte[6:0];
	assign ext_len = {plen_q[55:0], rx_byte};
	assign br_inc  = br_q + 64'd1;
	assign in_pay  = (phase_q == wfp_pkg::PH_PAYLOAD);
	assign keep    = in_pay && (kept_q < max_size);
	assign ovf_nxt = ovf_q | (in_pay & ~keep);
	assign key_idx = 2'(4'd4 - left_q);

	always_comb begin
		unique case (phase_q)
			wfp_pkg::PH_HDR1:    end_now = !rx_byte[7] && (len7 == 7'd0);
			wfp_pkg::PH_EXTLEN:  end_now = (left_q == 4'd1) && !mask_q && (ext_len == 64'd0);
			wfp_pkg::PH_MASK:    end_now = (left_q == 4'd1) && (plen_q == 64'd0);
			wfp_pkg::PH_PAYLOAD: end_now = (br_inc == plen_q);
			default:             end_now = 1'b0;
		endcase
	end

	always_comb begin
		if (ovf_nxt)
			type_end = wfp_pkg::TYPE_LARGE;
		else if (opcode_q != wfp_pkg::OP_CONT)
			type_end = wfp_pkg::map_opcode(opcode_q);
		else
			type_end = mtype_q;
	end

	assign emit_end = end_now && (fin_q || deliver);
	assign push     = acc && (keep || emit_end);

	always_comb begin
		push_entry.has_pay  = keep;
		push_entry.pay_byte = rx_byte ^ key_q[8*br_q[1:0] +: 8];
		push_entry.has_end  = emit_end;
		push_entry.end_type = type_end;
		push_entry.end_fin  = fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wfp_pkg::PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			left_q   <= 4'd0;
			plen_q   <= 64'd0;
			key_q    <= 32'd0;
			br_q     <= 64'd0;
			kept_q   <= 25'd0;
			mtype_q  <= wfp_pkg::TYPE_TEXT;
			ovf_q    <= 1'b0;
		end else if (acc) begin
			unique case (phase_q)
				wfp_pkg::PH_HDR1: begin
					mask_q <= rx_byte[7];
					plen_q <= 64'd0;
					if (len7 == wfp_pkg::LEN_EXT64) begin
						left_q  <= 4'd8;
						phase_q <= wfp_pkg::PH_EXTLEN;
					end else if (len7 == wfp_pkg::LEN_EXT16) begin
						left_q  <= 4'd2;
						phase_q <= wfp_pkg::PH_EXTLEN;
					end else begin
						plen_q <= {57'd0, len7};
						if (rx_byte[7]) begin
							left_q  <= 4'd4;
							phase_q <= wfp_pkg::PH_MASK;
						end else if (len7 != 7'd0) begin
							phase_q <= wfp_pkg::PH_PAYLOAD;
						end
					end
				end
				wfp_pkg::PH_EXTLEN: begin
					plen_q <= ext_len;
					left_q <= left_q - 4'd1;
					if (left_q == 4'd1) begin
						if (mask_q) begin
							left_q  <= 4'd4;
							phase_q <= wfp_pkg::PH_MASK;
						end else if (ext_len != 64'd0) begin
							phase_q <= wfp_pkg::PH_PAYLOAD;
						end
					end
				end
				wfp_pkg::PH_MASK: begin
					key_q[8*key_idx +: 8] <= rx_byte;
					left_q <= left_q - 4'd1;
					if (left_q == 4'd1 && plen_q != 64'd0)
						phase_q <= wfp_pkg::PH_PAYLOAD;
				end
				wfp_pkg::PH_PAYLOAD: begin
					br_q  <= br_inc;
					ovf_q <= ovf_nxt;
					if (keep)
						kept_q <= kept_q + 25'd1;
				end
				default: begin
					fin_q    <= rx_byte[7];
					opcode_q <= rx_byte[3:0];
					mask_q   <= 1'b0;
					plen_q   <= 64'd0;
					key_q    <= 32'd0;
					br_q     <= 64'd0;
					ovf_q    <= 1'b0;
					left_q   <= 4'd0;
					phase_q  <= wfp_pkg::PH_HDR1;
				end
			endcase
			// frame complete: fold the type, end the message where due
			if (end_now) begin
				phase_q <= wfp_pkg::PH_HDR0;
				mtype_q <= type_end;
				if (emit_end)
					kept_q <= 25'd0;
			end
		end
	end

endmodule

### rtl/wfp_queue.sv
// ----------------------------------------------------------------------------
// wfp_queue - short entry queue between parser and result output
// Small circular buffer with a fill count.
// ----------------------------------------------------------------------------
module wfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wfp_pkg::entry_t     push_entry,
	input  logic                pop,
	output wfp_pkg::entry_t     head,
	output logic                nonempty,
	output logic                full
);

	wfp_pkg::entry_t mem_q [wfp_pkg::QDepth];
	logic [wfp_pkg::QPtrW-1:0] wr_q;
	logic [wfp_pkg::QPtrW-1:0] rd_q;
	logic [wfp_pkg::QCntW-1:0] cnt_q;

	assign head     = mem_q[rd_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == wfp_pkg::QCntW'(wfp_pkg::QDepth));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push == pop) |=> $stable(cnt_q))
		else $error("queue count moved without net request");
`endif

endmodule

### rtl/wfp_back.sv
// ----------------------------------------------------------------------------
// wfp_back - result output stage
// Holds one queue entry and sends its payload and end results in order.
// ----------------------------------------------------------------------------
module wfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wfp_pkg::entry_t     head,
	input  logic                nonempty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [7:0]          payload_byte,
	output logic [2:0]          msg_type,
	output logic                fin_flag,
	output logic                last
);

	wfp_pkg::entry_t cur_q;
	logic            cur_v_q;
	logic            end_ph_q;
	logic            take;
	logic            done;

	assign out_valid = cur_v_q;
	assign take      = cur_v_q && !out_stall;
	assign done      = take && (end_ph_q || !cur_q.has_end);
	assign pop       = nonempty && (!cur_v_q || done);

	assign kind         = end_ph_q;
	assign payload_byte = end_ph_q ? 8'd0 : cur_q.pay_byte;
	assign msg_type     = end_ph_q ? cur_q.end_type : wfp_pkg::TYPE_TEXT;
	assign fin_flag     = end_ph_q & cur_q.end_fin;
	assign last         = end_ph_q | ~cur_q.has_end;

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q  <= 1'b0;
			end_ph_q <= 1'b0;
		end else if (pop) begin
			cur_v_q  <= 1'b1;
			end_ph_q <= !head.has_pay;
		end else if (done) begin
			cur_v_q  <= 1'b0;
		end else if (take) begin
			end_ph_q <= 1'b1;
		end
	end

endmodule
